[rtl/fbfc_pkg.sv]
// shared types and constants for the frame fill and cursor engine
package fbfc_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int CursorSize = 16;
  localparam int StoreDepth = MaxWidth * MaxHeight;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int CellW      = $clog2(CursorSize * CursorSize);
  localparam int CurW       = $clog2(CursorSize);
  localparam int CoordW     = 9;
  localparam int PixW       = 32;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;

  typedef enum logic [2:0] {
    CMD_PUT   = 3'd0,
    CMD_GET   = 3'd1,
    CMD_FILL  = 3'd2,
    CMD_DRAW  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_code_t;

  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BITS_A = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BITS_B = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BITS_C = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BITS_D = 3'd5;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] rect_width;
    logic [CoordW-1:0] rect_height;
    logic [PixW-1:0]   colour_value;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] read_data;
    logic            origin_inside;
  } out_item_t;

endpackage

[rtl/framebuffer_fill_and_cursor_engine.sv]
// frame fill and cursor engine top level
// Each command is one beat in and one beat out. Put, get outside the screen, clear before any
// draw and unused commands go straight to the output register; get inside the screen passes
// through a read wait state and a done state first. Fill writes one pixel a cycle over the
// clipped rectangle through the single write port of the frame store. Draw and clear cursor
// step through all 256 bitmap cells; each set cell inside the screen adds a read-modify-write
// on the frame store. Results sit in an output register and are held while the output stalls;
// a new command is taken once the previous result has been delivered.
module framebuffer_fill_and_cursor_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fbfc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fbfc_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [fbfc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [fbfc_pkg::CfgDataW-1:0]   cfg_value
);
  import fbfc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_CUR, S_CUR_RD, S_CUR_WAIT, S_CUR_WR, S_GET_WAIT, S_GET_DONE, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [CoordW-1:0] active_width, active_height;
  logic [CursorSize*CursorSize-1:0] cursor_bits;
  logic              cursor_shown;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= CoordW'(MaxWidth);
      active_height <= CoordW'(MaxHeight);
      cursor_bits   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  active_width  <= cfg_value[CoordW-1:0];
        REG_HEIGHT: active_height <= cfg_value[CoordW-1:0];
        REG_BITS_A: cursor_bits[63:0]    <= cfg_value;
        REG_BITS_B: cursor_bits[127:64]  <= cfg_value;
        REG_BITS_C: cursor_bits[191:128] <= cfg_value;
        REG_BITS_D: cursor_bits[255:192] <= cfg_value;
        default: ;
      endcase
    end
  end

  // effective active area
  logic [CoordW:0] eff_w, eff_h;
  assign eff_w = ({1'b0, active_width}  > (CoordW+1)'(MaxWidth))  ?
                 (CoordW+1)'(MaxWidth)  : {1'b0, active_width};
  assign eff_h = ({1'b0, active_height} > (CoordW+1)'(MaxHeight)) ?
                 (CoordW+1)'(MaxHeight) : {1'b0, active_height};

  // latched command
  in_item_t          item;
  logic [CoordW:0]   x_end, y_end, cx, cy;
  logic [CellW-1:0]  slot;
  logic [PixW-1:0]   out_rd;
  logic              out_org;

  // frame store, one write and one read port
  logic [PixW-1:0]  frame_store [StoreDepth];
  logic [PixW-1:0]  saved_under [CursorSize*CursorSize];
  logic [PixW-1:0]  saved_drawn [CursorSize*CursorSize];
  logic             fs_we;
  logic [AddrW-1:0] fs_waddr, fs_raddr;
  logic [PixW-1:0]  fs_wdata, fs_rdata, su_rdata, sd_rdata;
  logic             sv_we;
  logic [PixW-1:0]  sv_under;

  always_ff @(posedge clk) begin
    if (fs_we) frame_store[fs_waddr] <= fs_wdata;
    fs_rdata <= frame_store[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (sv_we) begin
      saved_under[slot] <= sv_under;
      saved_drawn[slot] <= item.colour_value;
    end
    su_rdata <= saved_under[slot];
    sd_rdata <= saved_drawn[slot];
  end

  // address of (cx, cy) and of the incoming item
  logic [2*(CoordW+1)-1:0] prod_cur, prod_in;
  assign prod_cur = cy * eff_w + cx;
  assign prod_in  = {{(CoordW+1){1'b0}}, 1'b0, in_data.pos_y} * eff_w
                    + {{(CoordW+2){1'b0}}, in_data.pos_x};

  // cursor cell position and bitmap bit
  logic [CurW-1:0] crow, ccol;
  logic [4:0]      cbyte;
  logic            cbit, cin;
  assign crow  = slot[CellW-1:CurW];
  assign ccol  = slot[CurW-1:0];
  assign cbyte = slot[CellW-1:3];
  assign cbit  = cursor_bits[{cbyte, 3'b111 - slot[2:0]}];
  assign cin   = ((cx + (CoordW+1)'(ccol)) < eff_w) && ((cy + (CoordW+1)'(crow)) < eff_h);

  logic [CoordW:0] px, py;
  assign px = cx + (CoordW+1)'(ccol);
  assign py = cy + (CoordW+1)'(crow);
  logic [2*(CoordW+1)-1:0] prod_cell;
  assign prod_cell = py * eff_w + px;

  logic in_org;
  assign in_org = ({1'b0, in_data.pos_x} < eff_w) && ({1'b0, in_data.pos_y} < eff_h);

  logic is_draw;
  assign is_draw = (item.cmd == CMD_DRAW);

  // write and read port control
  always_comb begin
    fs_we    = 1'b0;
    fs_waddr = prod_cur[AddrW-1:0];
    fs_wdata = item.colour_value;
    fs_raddr = prod_in[AddrW-1:0];
    sv_we    = 1'b0;
    sv_under = fs_rdata;
    unique case (state)
      S_IDLE: begin
        fs_waddr = prod_in[AddrW-1:0];
        fs_wdata = in_data.colour_value;
        fs_we    = in_valid && in_org && (in_data.cmd == CMD_PUT);
      end
      S_FILL:     fs_we = 1'b1;
      S_GET_WAIT: fs_raddr = prod_cur[AddrW-1:0];
      S_CUR_RD, S_CUR_WAIT: fs_raddr = prod_cell[AddrW-1:0];
      S_CUR_WR: begin
        fs_waddr = prod_cell[AddrW-1:0];
        if (is_draw) begin
          fs_we = 1'b1;
          sv_we = 1'b1;
        end else begin
          fs_we    = (fs_rdata == sd_rdata);
          fs_wdata = su_rdata;
        end
      end
      default: ;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = '{read_data: out_rd, origin_inside: out_org};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cursor_shown <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          item    <= in_data;
          out_org <= in_org;
          out_rd  <= '0;
          cx      <= {1'b0, in_data.pos_x};
          cy      <= {1'b0, in_data.pos_y};
          slot    <= '0;
          x_end   <= (({1'b0, in_data.pos_x} + {1'b0, in_data.rect_width}) > eff_w) ?
                     eff_w : ({1'b0, in_data.pos_x} + {1'b0, in_data.rect_width});
          y_end   <= (({1'b0, in_data.pos_y} + {1'b0, in_data.rect_height}) > eff_h) ?
                     eff_h : ({1'b0, in_data.pos_y} + {1'b0, in_data.rect_height});
          priority if (in_data.cmd == CMD_GET && in_org) begin
            state <= S_GET_WAIT;
          end else if (in_data.cmd == CMD_FILL && in_org &&
                       in_data.rect_width != '0 && in_data.rect_height != '0) begin
            state <= S_FILL;
          end else if (in_data.cmd == CMD_DRAW) begin
            cursor_shown <= 1'b1;
            state <= S_CUR;
          end else if (in_data.cmd == CMD_CLEAR && cursor_shown) begin
            state <= S_CUR;
          end else begin
            state <= S_OUT;
          end
        end
        S_GET_WAIT: state <= S_GET_DONE;
        S_GET_DONE: begin
          out_rd <= fs_rdata;
          state  <= S_OUT;
        end
        // one pixel a cycle across the clipped rectangle
        S_FILL: begin
          if (cx + 1'b1 >= x_end) begin
            cx <= {1'b0, item.pos_x};
            if (cy + 1'b1 >= y_end) state <= S_OUT;
            else cy <= cy + 1'b1;
          end else begin
            cx <= cx + 1'b1;
          end
        end
        // walk bitmap cells, read-modify-write on set cells inside the screen
        S_CUR: begin
          if (cbit && cin) state <= S_CUR_RD;
          else if (slot == '1) state <= S_OUT;
          else slot <= slot + 1'b1;
        end
        S_CUR_RD:   state <= S_CUR_WAIT;
        S_CUR_WAIT: state <= S_CUR_WR;
        S_CUR_WR: begin
          if (slot == '1) state <= S_OUT;
          else begin
            slot  <= slot + 1'b1;
            state <= S_CUR;
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/fbfc_checker.sv]
// port checker for the frame fill and cursor engine
module fbfc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input fbfc_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input fbfc_pkg::out_item_t             out_data
);
  import fbfc_pkg::*;

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // results and input acceptance never overlap
  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // an accepted beat stalls input next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // non-get commands that go straight to the result give zero read data
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && $past(in_valid && !in_stall && in_data.cmd != CMD_GET)
    |-> out_data.read_data == '0)
    else $error("nonzero read data for non-get command");

endmodule

bind framebuffer_fill_and_cursor_engine fbfc_checker u_fbfc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
